// ===== rtl/kscr_pkg.sv =====
// ----------------------------------------------------------------------------
// kscr_pkg
// Shared types and constants of the kinetic scroller: field widths,
// operation codes, item classes and the queued item record.
// ----------------------------------------------------------------------------
package kscr_pkg;

    localparam int POS_W         = 25;
    localparam int VAL_W         = 16;
    localparam int OP_W          = 3;
    localparam int CFG_W         = 16;
    localparam int CFG_ADDR_W    = 2;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 56;
    localparam int OUT_TUSER_W   = 2;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_PRESS   = 3'd1;
    localparam logic [OP_W-1:0] OP_MOVE    = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLICK   = 3'd4;
    localparam logic [OP_W-1:0] OP_JUMP    = 3'd5;

    localparam logic [CFG_ADDR_W-1:0] CFG_VIEW_W    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_VIEW_H    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CONTENT_W = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CONTENT_H = 2'd3;

    typedef enum logic [2:0] {
        K_NONE,
        K_TICK,
        K_PRESS,
        K_MOVE,
        K_RELEASE,
        K_FLICK,
        K_JUMP
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic signed [VAL_W-1:0]  x;
        logic signed [VAL_W-1:0]  y;
        logic                     ease;
    } t_item;

endpackage

// ===== rtl/kscr_front.sv =====
// ----------------------------------------------------------------------------
// kscr_front
// Input side: takes beats, decodes the operation into an item class and
// holds up to two items for the physics engine.
// ----------------------------------------------------------------------------
module kscr_front
    import kscr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // x_value, y_value, animate_jump
    input  logic [OP_W-1:0]        s_axis_tuser,   // operation
    output t_item                  o_item,
    output logic                   o_item_valid,
    input  logic                   i_item_pop
);

    t_item       r_queue [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    t_item       c_item;
    logic        c_push;

    always_comb begin
        c_item.x    = s_axis_tdata[VAL_W-1:0];
        c_item.y    = s_axis_tdata[2*VAL_W-1:VAL_W];
        c_item.ease = s_axis_tdata[2*VAL_W];
        unique case (s_axis_tuser)
            OP_TICK:    c_item.kind = K_TICK;
            OP_PRESS:   c_item.kind = K_PRESS;
            OP_MOVE:    c_item.kind = K_MOVE;
            OP_RELEASE: c_item.kind = K_RELEASE;
            OP_FLICK:   c_item.kind = K_FLICK;
            OP_JUMP:    c_item.kind = K_JUMP;
            default:    c_item.kind = K_NONE;
        endcase
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign c_push        = s_axis_tvalid && s_axis_tready;
    assign o_item        = r_queue[r_rd];
    assign o_item_valid  = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_push) begin
                r_queue[r_wr] <= c_item;
                r_wr          <= !r_wr;
            end
            if (i_item_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(c_push) - 2'(i_item_pop);
        end
    end

endmodule

// ===== rtl/kscr_div.sv =====
// ----------------------------------------------------------------------------
// kscr_div
// Constant-ratio divider: floor-divides an unsigned dividend below 2^32 by
// 10, 20, 50 or 100 through a reciprocal multiply and by 2 through a shift.
// ----------------------------------------------------------------------------
module kscr_div #(
    parameter int NW = 34,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);

    // ceil(2^35/25) and ceil(2^34/5), exact for any 32-bit dividend
    localparam logic [31:0] RECIP_25 = 32'h51EB851F;
    localparam logic [31:0] RECIP_5  = 32'hCCCCCCCD;

    logic [31:0]   r_n;
    logic [DW-1:0] r_den;
    logic [63:0]   r_prod;
    logic          r_busy;
    logic          r_done;
    logic [31:0]   c_recip;
    logic [NW-1:0] c_quo;

    assign c_recip = (r_den == DW'(100) || r_den == DW'(50)) ? RECIP_25 : RECIP_5;

    always_comb begin
        case (r_den)
            DW'(100): c_quo = NW'(r_prod >> 37);
            DW'(50),
            DW'(20):  c_quo = NW'(r_prod >> 36);
            DW'(10):  c_quo = NW'(r_prod >> 35);
            DW'(2):   c_quo = NW'(r_n >> 1);
            default:  c_quo = NW'(r_n);
        endcase
    end

    assign o_done     = r_done;
    assign o_quotient = c_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_go;
            r_done <= 1'b0;
            if (i_go) begin
                r_n   <= i_dividend[31:0];
                r_den <= i_divisor;
            end
            if (r_busy) begin
                r_prod <= 64'(r_n) * 64'(c_recip);
                r_done <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/kscr_back.sv =====
// ----------------------------------------------------------------------------
// kscr_back
// Physics engine: runs one item at a time through a sequencer over the two
// axes, sharing one constant-ratio divider, and holds the result beat.
// ----------------------------------------------------------------------------
module kscr_back
    import kscr_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  t_item                   i_item,
    input  logic                    i_item_valid,
    output logic                    o_item_pop,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,  // shown_x, shown_y
    output logic [OUT_TUSER_W-1:0]  m_axis_tuser   // report, animating
);

    localparam int AW = (FRACTION_BITS + 19 > 28) ? FRACTION_BITS + 19 : 28;
    localparam int NW = AW + 7;
    localparam logic [AW-1:0] HALF = AW'(1) << (FRACTION_BITS - 1);
    localparam logic [NW-1:0] ONE  = NW'(1) << FRACTION_BITS;

    localparam logic [1:0] LOCK_NONE  = 2'd0;
    localparam logic [1:0] LOCK_HORIZ = 2'd1;
    localparam logic [1:0] LOCK_VERT  = 2'd2;
    localparam logic [1:0] LOCK_FREE  = 2'd3;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_TLOAD = 16'h0002,
        S_MLOAD = 16'h0004,
        S_C1    = 16'h0008,
        S_C2    = 16'h0010,
        S_C3    = 16'h0020,
        S_S1    = 16'h0040,
        S_S2    = 16'h0080,
        S_AX    = 16'h0100,
        S_TFIN  = 16'h0200,
        S_M0    = 16'h0400,
        S_M1    = 16'h0800,
        S_FL    = 16'h1000,
        S_JP    = 16'h2000,
        S_WAIT  = 16'h4000,
        S_OUT   = 16'h8000
    } t_state;

    typedef struct packed {
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] gx;
        logic signed [POS_W-1:0] gy;
        logic signed [POS_W-1:0] psx;
        logic signed [POS_W-1:0] psy;
        logic signed [POS_W-1:0] rx;
        logic signed [POS_W-1:0] ry;
        logic signed [VAL_W-1:0] ppx;
        logic signed [VAL_W-1:0] ppy;
        logic signed [VAL_W-1:0] ax;
        logic signed [VAL_W-1:0] ay;
        logic [1:0]              lock;
        logic                    drag;
        logic                    act;
    } t_phys;

    function automatic logic signed [POS_W-1:0] f_sat(input logic signed [AW-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v[AW-1:POS_W-1] == '0 || v[AW-1:POS_W-1] == '1) begin
            r = v[POS_W-1:0];
        end else if (v[AW-1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] f_mag(input logic signed [AW-1:0] v);
        return v[AW-1] ? AW'(-v) : AW'(v);
    endfunction

    function automatic logic [VAL_W:0] f_mag16(input logic signed [VAL_W:0] v);
        return v[VAL_W] ? (VAL_W+1)'(-v) : (VAL_W+1)'(v);
    endfunction

    // configuration and scroller state
    logic [CFG_W-1:0] r_vw, r_vh, r_cw, r_ch;
    t_phys            r_ph, n_ph;
    t_state           r_state, n_state, r_ret, n_ret;

    // per-item working registers
    logic                    r_axis, n_axis;
    logic                    r_mv, n_mv;
    logic                    r_ease, n_ease;
    logic                    r_rep, n_rep;
    logic signed [VAL_W-1:0] r_xv, n_xv, r_yv, n_yv;
    logic signed [POS_W-1:0] r_p, n_p, r_q, n_q;
    logic signed [AW-1:0]    r_v, n_v;
    logic [31:0]             r_m1, n_m1, r_m2, n_m2, r_m3, n_m3;
    logic                    r_neg;

    // result beat
    logic                    r_ovalid;
    logic signed [POS_W-1:0] r_ox, r_oy;
    logic                    r_orep, r_oact;
    logic                    c_load;

    // divider hookup
    logic                    div_go, div_done;
    logic signed [AW-1:0]    div_val;
    logic [6:0]              div_num, div_den;
    logic [NW-1:0]           div_dividend, div_quo;
    logic signed [AW-1:0]    c_qs;

    // per-axis views
    logic signed [POS_W-1:0] c_pos, c_prv, c_goal, c_ps;
    logic signed [VAL_W-1:0] c_val, c_pp;
    logic signed [AW-1:0]    c_right, c_bottom, c_edge;
    logic [CFG_W-1:0]        c_cw_eff, c_ch_eff;

    assign c_cw_eff = (r_cw > r_vw) ? r_cw : r_vw;
    assign c_ch_eff = (r_ch > r_vh) ? r_ch : r_vh;
    assign c_right  = AW'($signed({1'b0, r_vw}) - $signed({1'b0, c_cw_eff})) <<< FRACTION_BITS;
    assign c_bottom = AW'($signed({1'b0, r_vh}) - $signed({1'b0, c_ch_eff})) <<< FRACTION_BITS;

    assign c_pos  = r_axis ? r_ph.sx  : r_ph.sy;
    assign c_prv  = r_axis ? r_ph.px  : r_ph.py;
    assign c_goal = r_axis ? r_ph.gx  : r_ph.gy;
    assign c_ps   = r_axis ? r_ph.psx : r_ph.psy;
    assign c_pp   = r_axis ? r_ph.ppx : r_ph.ppy;
    assign c_val  = r_axis ? r_xv     : r_yv;
    assign c_edge = r_axis ? c_right  : c_bottom;

    assign div_dividend = NW'(f_mag(div_val)) * NW'(div_num) + NW'(div_den >> 1);
    assign c_qs = r_neg ? -$signed(AW'(div_quo)) : $signed(AW'(div_quo));

    kscr_div #(
        .NW (NW),
        .DW (7)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        logic signed [VAL_W-1:0] lx, ly;
        logic [1:0]              lk;
        logic signed [AW-1:0]    t;
        logic [VAL_W:0]          adx, ady;

        n_state = r_state;
        n_ret   = r_ret;
        n_ph    = r_ph;
        n_axis  = r_axis;
        n_mv    = r_mv;
        n_ease  = r_ease;
        n_rep   = r_rep;
        n_xv    = r_xv;
        n_yv    = r_yv;
        n_p     = r_p;
        n_q     = r_q;
        n_v     = r_v;
        n_m1    = r_m1;
        n_m2    = r_m2;
        n_m3    = r_m3;
        div_go  = 1'b0;
        div_val = '0;
        div_num = 7'd1;
        div_den = 7'd1;
        o_item_pop = 1'b0;
        c_load  = 1'b0;
        lx = '0;
        ly = '0;
        lk = r_ph.lock;
        t  = '0;
        adx = '0;
        ady = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    o_item_pop = 1'b1;
                    n_xv   = i_item.x;
                    n_yv   = i_item.y;
                    n_ease = i_item.ease;
                    n_rep  = 1'b0;
                    n_axis = 1'b0;
                    n_mv   = 1'b0;
                    n_state = S_OUT;
                    unique case (i_item.kind)
                        K_TICK: begin
                            if (r_ph.act) n_state = S_TLOAD;
                        end
                        K_PRESS: begin
                            lx = i_item.x;
                            ly = i_item.y;
                            if (r_ph.act && r_ph.lock == LOCK_HORIZ) begin
                                ly = r_ph.ay;
                            end else if (r_ph.act && r_ph.lock == LOCK_VERT) begin
                                lx = r_ph.ax;
                            end else begin
                                n_ph.lock = LOCK_NONE;
                                n_ph.ax   = lx;
                                n_ph.ay   = ly;
                            end
                            n_ph.drag = 1'b1;
                            n_ph.ppx  = lx;
                            n_ph.ppy  = ly;
                            n_ph.psx  = r_ph.sx;
                            n_ph.gx   = r_ph.sx;
                            n_ph.psy  = r_ph.sy;
                            n_ph.gy   = r_ph.sy;
                        end
                        K_MOVE: begin
                            n_mv    = 1'b1;
                            n_state = S_M0;
                        end
                        K_RELEASE: begin
                            n_ph.drag = 1'b0;
                        end
                        K_FLICK: begin
                            if (r_ph.drag) begin
                                if (lk == LOCK_NONE) begin
                                    lk = (f_mag16((VAL_W+1)'(i_item.x)) >
                                          f_mag16((VAL_W+1)'(i_item.y))) ? LOCK_HORIZ
                                                                         : LOCK_VERT;
                                end
                                n_ph.lock = lk;
                                if (lk == LOCK_HORIZ) n_yv = '0;
                                else if (lk == LOCK_VERT) n_xv = '0;
                                n_state = S_FL;
                            end
                        end
                        K_JUMP: begin
                            n_state = S_JP;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_TLOAD: begin
                if (r_ph.drag) begin
                    n_p = c_goal;
                    n_q = c_goal;
                    n_state = S_S1;
                end else begin
                    n_p = c_pos;
                    n_q = c_prv;
                    n_v = AW'(c_pos);
                    n_state = S_C1;
                end
            end

            S_MLOAD: begin
                t   = (AW'(c_val) - AW'(c_pp)) <<< FRACTION_BITS;
                n_v = AW'(f_sat(t + AW'(c_ps)));
                n_state = S_C1;
            end

            // damping against the upper edge at zero
            S_C1: begin
                if (f_mag(r_v) < HALF) begin
                    n_v = '0;
                    n_state = S_C2;
                end else if (!r_v[AW-1] && r_v != '0) begin
                    div_go  = 1'b1;
                    div_val = r_v;
                    div_num = r_mv ? 7'd1 : 7'd93;
                    div_den = r_mv ? 7'd2 : 7'd100;
                    n_ret   = S_C1;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_C2;
                end
            end

            // damping against the lower edge
            S_C2: begin
                t = r_v - c_edge;
                if (f_mag(t) < HALF) begin
                    n_v = c_edge;
                    n_state = S_C3;
                end else if (r_v < c_edge) begin
                    div_go  = 1'b1;
                    div_val = t;
                    div_num = r_mv ? 7'd1 : 7'd93;
                    div_den = r_mv ? 7'd2 : 7'd100;
                    n_ret   = S_C2;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_C3;
                end
            end

            S_C3: begin
                if (r_mv) begin
                    if (r_axis) n_ph.gx = r_v[POS_W-1:0];
                    else        n_ph.gy = r_v[POS_W-1:0];
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_state = S_MLOAD;
                    end else begin
                        if (!n_ph.act) begin
                            n_ph.act = 1'b1;
                            n_ph.rx  = '0;
                            n_ph.ry  = '0;
                        end
                        n_state = S_OUT;
                    end
                end else if (r_v != AW'(r_p)) begin
                    div_go  = 1'b1;
                    div_val = AW'(r_p) - AW'(r_q);
                    div_num = 7'd9;
                    div_den = 7'd10;
                    n_ret   = S_C3;
                    n_state = S_WAIT;
                end else begin
                    n_state = S_S1;
                end
            end

            // verlet step
            S_S1: begin
                n_p = f_sat(AW'(r_p) + AW'(r_p) - AW'(r_q));
                n_q = r_p;
                n_state = S_S2;
            end

            // friction with stop threshold
            S_S2: begin
                t = AW'(r_p) - AW'(r_q);
                if (NW'(f_mag(t)) * NW'(100) > ONE) begin
                    div_go  = 1'b1;
                    div_val = t;
                    div_num = 7'd19;
                    div_den = 7'd20;
                    n_ret   = S_S2;
                    n_state = S_WAIT;
                end else begin
                    n_p = r_q;
                    n_state = S_AX;
                end
            end

            S_AX: begin
                if (r_axis) begin
                    n_ph.sx = r_p;
                    n_ph.px = r_q;
                    n_state = S_TFIN;
                end else begin
                    n_ph.sy = r_p;
                    n_ph.py = r_q;
                    n_axis  = 1'b1;
                    n_state = S_TLOAD;
                end
            end

            S_TFIN: begin
                if (r_ph.rx != r_ph.sx || r_ph.ry != r_ph.sy) begin
                    n_rep = 1'b1;
                end else if (!r_ph.drag) begin
                    n_ph.act = 1'b0;
                    n_rep    = 1'b1;
                end
                n_ph.rx = r_ph.sx;
                n_ph.ry = r_ph.sy;
                n_state = S_OUT;
            end

            S_M0: begin
                adx  = f_mag16((VAL_W+1)'(r_xv) - (VAL_W+1)'(r_ph.ax));
                ady  = f_mag16((VAL_W+1)'(r_yv) - (VAL_W+1)'(r_ph.ay));
                n_m1 = 32'(adx) * 32'd10000;
                n_m2 = 32'(ady) * 32'd24142;
                n_m3 = 32'(ady) * 32'd4142;
                n_state = S_M1;
            end

            S_M1: begin
                if (lk == LOCK_NONE) begin
                    if (r_m1 > r_m2)      lk = LOCK_HORIZ;
                    else if (r_m1 < r_m3) lk = LOCK_VERT;
                    else                  lk = LOCK_FREE;
                end
                n_ph.lock = lk;
                if (lk == LOCK_HORIZ)     n_yv = r_ph.ay;
                else if (lk == LOCK_VERT) n_xv = r_ph.ax;
                n_state = r_ph.drag ? S_MLOAD : S_OUT;
            end

            S_FL: begin
                div_go  = 1'b1;
                div_val = AW'(c_val) <<< FRACTION_BITS;
                div_num = 7'd1;
                div_den = 7'd50;
                n_ret   = S_FL;
                n_state = S_WAIT;
            end

            S_JP: begin
                t = AW'(f_sat(AW'(c_val) <<< FRACTION_BITS));
                if (r_ease) begin
                    div_go  = 1'b1;
                    div_val = t - AW'(c_prv);
                    div_num = 7'd1;
                    div_den = 7'd20;
                    n_ret   = S_JP;
                    n_state = S_WAIT;
                end else begin
                    if (r_axis) begin
                        n_ph.sx = t[POS_W-1:0];
                        n_ph.px = t[POS_W-1:0];
                    end else begin
                        n_ph.sy = t[POS_W-1:0];
                        n_ph.py = t[POS_W-1:0];
                    end
                    if (!r_axis) begin
                        n_axis = 1'b1;
                    end else begin
                        if (!n_ph.act) begin
                            n_ph.act = 1'b1;
                            n_ph.rx  = '0;
                            n_ph.ry  = '0;
                        end
                        n_state = S_OUT;
                    end
                end
            end

            S_WAIT: begin
                if (div_done) begin
                    unique case (r_ret)
                        S_C1: begin
                            n_v = AW'(f_sat(c_qs));
                            n_state = S_C2;
                        end
                        S_C2: begin
                            n_v = AW'(f_sat(c_qs + c_edge));
                            n_state = S_C3;
                        end
                        S_C3: begin
                            n_q = f_sat(r_v - c_qs);
                            n_p = r_v[POS_W-1:0];
                            n_state = S_S1;
                        end
                        S_S2: begin
                            n_p = f_sat(AW'(r_q) + c_qs);
                            n_state = S_AX;
                        end
                        S_FL, S_JP: begin
                            if (r_axis) n_ph.sx = f_sat(AW'(c_prv) + c_qs);
                            else        n_ph.sy = f_sat(AW'(c_prv) + c_qs);
                            if (!r_axis) begin
                                n_axis  = 1'b1;
                                n_state = r_ret;
                            end else begin
                                if (r_ret == S_FL) begin
                                    n_rep     = 1'b1;
                                    n_ph.drag = 1'b0;
                                end
                                if (!n_ph.act) begin
                                    n_ph.act = 1'b1;
                                    n_ph.rx  = '0;
                                    n_ph.ry  = '0;
                                end
                                n_state = S_OUT;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_OUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    c_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ph     <= '0;
            r_vw     <= '0;
            r_vh     <= '0;
            r_cw     <= '0;
            r_ch     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_ph    <= n_ph;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_VIEW_W:    r_vw <= i_cfg_wdata;
                    CFG_VIEW_H:    r_vh <= i_cfg_wdata;
                    CFG_CONTENT_W: r_cw <= i_cfg_wdata;
                    CFG_CONTENT_H: r_ch <= i_cfg_wdata;
                    default:       r_vw <= r_vw;
                endcase
            end
            if (c_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis <= n_axis;
        r_mv   <= n_mv;
        r_ease <= n_ease;
        r_rep  <= n_rep;
        r_xv   <= n_xv;
        r_yv   <= n_yv;
        r_p    <= n_p;
        r_q    <= n_q;
        r_v    <= n_v;
        r_m1   <= n_m1;
        r_m2   <= n_m2;
        r_m3   <= n_m3;
        if (div_go) begin
            r_neg <= div_val[AW-1];
        end
        if (c_load) begin
            r_ox   <= r_ph.sx;
            r_oy   <= r_ph.sy;
            r_orep <= r_rep;
            r_oact <= r_ph.act;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(OUT_TDATA_W - 2*POS_W)'(0), r_oy, r_ox};
    assign m_axis_tuser  = {r_oact, r_orep};

endmodule

// ===== rtl/kinetic_scroll_physics.sv =====
// ----------------------------------------------------------------------------
// kinetic_scroll_physics
// Two-axis kinetic scroller with drag damping, scroll lock, spring edges,
// verlet integration and friction, in signed fixed point.
// ----------------------------------------------------------------------------
// Usage: pointer, flick, jump and frame tick items come in on the s_axis
// stream (operation in tuser); every item gives exactly one beat on m_axis
// with the scroll position after it and the report/animating flags.
// Viewport and content sizes are written through the cfg port only while
// idle; the user must keep to this, as the block itself does not enforce it.
// An input queue of two items decouples the input from the engine.
// Press, release, unused codes and ignored ticks or flicks go straight to
// the result beat; moves, flicks while dragging, jumps and ticks while
// animating step through the per-axis sequencer, which shares one
// reciprocal divider. One item is in the engine at a time: the next is taken
// from the queue only once the result beat of the last has been loaded.
// Reset clears the scroller state and configuration to zero: no lock, not
// dragging, not animating.
// A stalled receiver holds the result beat; the engine then waits with the
// next finished result and the queue fills, dropping s_axis_tready.
// ----------------------------------------------------------------------------
module kinetic_scroll_physics
    import kscr_pkg::*;
#(
    parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,  // x_value, y_value, animate_jump
    input  logic [OP_W-1:0]         s_axis_tuser,  // operation
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,  // shown_x, shown_y
    output logic [OUT_TUSER_W-1:0]  m_axis_tuser   // report, animating
);

    t_item c_item;
    logic  c_item_valid;
    logic  c_item_pop;

    kscr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_item        (c_item),
        .o_item_valid  (c_item_valid),
        .i_item_pop    (c_item_pop)
    );

    kscr_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item        (c_item),
        .i_item_valid  (c_item_valid),
        .o_item_pop    (c_item_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
